@@ rtl/core/sssfd_pkg.sv @@
// sssfd_pkg: shared types and constants of the sliding slope fall detector
// no dependencies; imported by every module of the block

package sssfd_pkg;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FR_W = 6;
    localparam int THR_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAND_THR = 2'd2;

    localparam logic [FR_W-1:0] FRAME_RATE_RST = 6'd10;
    localparam logic signed [THR_W-1:0] FALL_THR_RST = 13'sd3;
    localparam logic signed [THR_W-1:0] STAND_THR_RST = -13'sd3;

    // input kind carried on s_tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic POSTURE_NORMAL = 1'b0;
    localparam logic POSTURE_FALLEN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_ACC,
        ST_TOP_SLOPE,
        ST_HGT_SLOPE,
        ST_DECIDE,
        ST_POST
    } top_state_t;

    typedef enum logic [2:0] {
        SL_IDLE,
        SL_MUL_A,
        SL_MUL_B,
        SL_SUB,
        SL_DIV,
        SL_DONE
    } slope_state_t;

endpackage

@@ rtl/core/sliding_slope_fall_detector.sv @@
// sliding_slope_fall_detector: top level, config registers, window walk and posture rule
// uses sssfd_pkg, sssfd_window_mem and sssfd_slope_unit
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | tuser: action; tdata: top_y, bottom_y
//  m_       | out       | tuser: window_full; tdata: posture, top_slope, height_slope
//  cfg_     | in        | cfg_index, cfg_data (frame_rate, fall/stand threshold)
//
// a clear or a sample that still fills the window goes through ST_POST back to ready
// a sample on a full window runs ST_PRIME, ST_ACC, both slopes, ST_DECIDE and ST_POST:
// one read port walks the window one entry a cycle, then one shared multiply/divide
// unit computes the top slope and then the height slope
// reset is synchronous; window storage is not cleared, entries are read only once written
// a result waits in the output register while m_tready is low; the next transaction is
// still taken and then holds in its last state until the register frees

module sliding_slope_fall_detector
    import sssfd_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int COORD_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata, // top_y, bottom_y
    input  logic s_tuser,                             // action

    output logic m_tvalid,
    input  logic m_tready,
    output logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_tdata, // posture, top_slope, height_slope
    output logic m_tuser,                                // window_full

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int SW = COORD_BITS + 1;
    localparam int SYW = COORD_BITS + NW + 1;
    localparam int SXYW = COORD_BITS + 2 * NW + 1;
    localparam int SXW = 2 * NW;
    localparam int SXXW = 3 * NW;
    localparam int DENW = 4 * NW;
    localparam int OUT_W = ((2 * COORD_BITS + 3 + 7) / 8) * 8;
    localparam int CW = (NW > FR_W + 1) ? NW : FR_W + 1;
    localparam int TW = (SW > THR_W) ? SW : THR_W;

    top_state_t state_reg, state_next;

    logic [FR_W-1:0] fr_reg;
    logic signed [THR_W-1:0] fall_thr_reg, stand_thr_reg;

    logic [NW-1:0] fill_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] rdaddr_reg;
    logic [NW-1:0] cnt_reg;
    logic fallen_reg;

    logic signed [SYW-1:0] top_sy_reg, hgt_sy_reg;
    logic signed [SXYW-1:0] top_sxy_reg, hgt_sxy_reg;
    logic [SXW-1:0] sx_reg, sq_reg;
    logic [SXXW-1:0] sxx_reg;
    logic [DENW-1:0] den_reg;

    logic signed [SW-1:0] ts_reg, hs_reg;
    logic res_posture_reg, res_full_reg;

    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic m_tuser_reg;

    logic [CW-1:0] fr2;
    logic [NW-1:0] n;
    logic in_acc, is_clear, win_full, acc_last, out_free;
    logic mem_we, slope_start, out_load;
    logic [COORD_BITS-1:0] top_in, bot_in;
    logic signed [COORD_BITS:0] hgt_in;
    logic [AW-1:0] wr_addr, ptr_inc, rdaddr_dec;
    logic [COORD_BITS-1:0] top_rd;
    logic signed [COORD_BITS:0] hgt_rd;
    logic signed [SYW-1:0] top_sy_next, hgt_sy_next;
    logic [SXW-1:0] sq_next;
    logic sel_hgt, slope_done, fallen_next;
    logic signed [SW-1:0] slope;

    // window length, clamped to 4..MAX_WINDOW
    always_comb begin
        fr2 = CW'({fr_reg, 1'b0});
        if (fr2 < CW'(4)) begin
            n = NW'(4);
        end else if (fr2 > CW'(MAX_WINDOW)) begin
            n = NW'(MAX_WINDOW);
        end else begin
            n = NW'(fr2);
        end
    end

    always_comb begin
        top_in = s_tdata[COORD_BITS-1:0];
        bot_in = s_tdata[2*COORD_BITS-1:COORD_BITS];
        hgt_in = $signed({1'b0, bot_in}) - $signed({1'b0, top_in});
        in_acc = s_tvalid && s_tready;
        is_clear = (s_tuser == ACT_CLEAR);
        win_full = (fill_reg >= n);
        acc_last = (cnt_reg == n - 1'b1);
        out_free = !m_tvalid_reg || m_tready;
        wr_addr = win_full ? ptr_reg : fill_reg[AW-1:0];
        ptr_inc = (NW'(ptr_reg) + 1'b1 == n) ? '0 : ptr_reg + 1'b1;
        rdaddr_dec = (rdaddr_reg == '0) ? AW'(n - 1'b1) : rdaddr_reg - 1'b1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (is_clear || !win_full) ? ST_POST : ST_PRIME;
                end
            end
            ST_PRIME: state_next = ST_ACC;
            ST_ACC: if (acc_last) state_next = ST_TOP_SLOPE;
            ST_TOP_SLOPE: if (slope_done) state_next = ST_HGT_SLOPE;
            ST_HGT_SLOPE: if (slope_done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_POST;
            ST_POST: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        mem_we = (state_reg == ST_IDLE) && in_acc && !is_clear;
        slope_start = ((state_reg == ST_ACC) && acc_last)
                   || ((state_reg == ST_TOP_SLOPE) && slope_done);
        out_load = (state_reg == ST_POST) && out_free;
        sel_hgt = (state_reg == ST_HGT_SLOPE);
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    sssfd_window_mem #(
        .MAX_WINDOW(MAX_WINDOW),
        .COORD_BITS(COORD_BITS)
    ) u_mem (
        .aclk(aclk),
        .wr_en(mem_we),
        .wr_addr(wr_addr),
        .top_wr(top_in),
        .hgt_wr(hgt_in),
        .rd_addr(rdaddr_reg),
        .top_rd_reg(top_rd),
        .hgt_rd_reg(hgt_rd)
    );

    sssfd_slope_unit #(
        .MAX_WINDOW(MAX_WINDOW),
        .COORD_BITS(COORD_BITS)
    ) u_slope (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(slope_start),
        .n(n),
        .sx(sx_reg),
        .den(den_reg),
        .sy(sel_hgt ? hgt_sy_reg : top_sy_reg),
        .sxy(sel_hgt ? hgt_sxy_reg : top_sxy_reg),
        .done(slope_done),
        .slope(slope)
    );

    // walk from newest to oldest: sy collects a suffix sum, sxy the sum of suffix sums
    always_comb begin
        top_sy_next = top_sy_reg + SYW'($signed({1'b0, top_rd}));
        hgt_sy_next = hgt_sy_reg + SYW'(hgt_rd);
        sq_next = sq_reg + SXW'({cnt_reg, 1'b1});
    end

    always_comb begin
        fallen_next = fallen_reg;
        if ((TW'(ts_reg) >= TW'(fall_thr_reg)) && (TW'(hs_reg) <= TW'(fall_thr_reg))) begin
            fallen_next = POSTURE_FALLEN;
        end else if (TW'(ts_reg) <= TW'(stand_thr_reg)) begin
            fallen_next = POSTURE_NORMAL;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fr_reg <= FRAME_RATE_RST;
            fall_thr_reg <= FALL_THR_RST;
            stand_thr_reg <= STAND_THR_RST;
            fill_reg <= '0;
            ptr_reg <= '0;
            fallen_reg <= POSTURE_NORMAL;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FRAME_RATE: begin
                        fr_reg <= cfg_data[FR_W-1:0];
                        fill_reg <= '0;
                        ptr_reg <= '0;
                    end
                    CFG_FALL_THR: fall_thr_reg <= $signed(cfg_data[THR_W-1:0]);
                    CFG_STAND_THR: stand_thr_reg <= $signed(cfg_data[THR_W-1:0]);
                    default: begin
                    end
                endcase
            end
            if ((state_reg == ST_IDLE) && in_acc) begin
                if (is_clear) begin
                    fill_reg <= '0;
                    ptr_reg <= '0;
                    fallen_reg <= POSTURE_NORMAL;
                end else if (!win_full) begin
                    fill_reg <= fill_reg + 1'b1;
                end else begin
                    ptr_reg <= ptr_inc;
                end
            end
            if (state_reg == ST_DECIDE) begin
                fallen_reg <= fallen_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                rdaddr_reg <= ptr_reg;
                ts_reg <= '0;
                hs_reg <= '0;
                res_posture_reg <= POSTURE_NORMAL;
                res_full_reg <= 1'b0;
            end
            ST_PRIME: begin
                rdaddr_reg <= rdaddr_dec;
                cnt_reg <= '0;
                top_sy_reg <= '0;
                top_sxy_reg <= '0;
                hgt_sy_reg <= '0;
                hgt_sxy_reg <= '0;
                sx_reg <= '0;
                sq_reg <= '0;
                sxx_reg <= '0;
                den_reg <= '0;
            end
            ST_ACC: begin
                rdaddr_reg <= rdaddr_dec;
                cnt_reg <= cnt_reg + 1'b1;
                top_sy_reg <= top_sy_next;
                top_sxy_reg <= top_sxy_reg + SXYW'(top_sy_next);
                hgt_sy_reg <= hgt_sy_next;
                hgt_sxy_reg <= hgt_sxy_reg + SXYW'(hgt_sy_next);
                // running n*Sxx - Sx^2 grows by the previous sum of squares
                sq_reg <= sq_next;
                sx_reg <= sx_reg + SXW'(NW'(cnt_reg + 1'b1));
                den_reg <= den_reg + DENW'(sxx_reg);
                sxx_reg <= sxx_reg + SXXW'(sq_next);
            end
            ST_TOP_SLOPE: if (slope_done) ts_reg <= slope;
            ST_HGT_SLOPE: if (slope_done) hs_reg <= slope;
            ST_DECIDE: begin
                res_posture_reg <= fallen_next;
                res_full_reg <= 1'b1;
            end
            ST_POST: begin
                if (out_free) begin
                    m_tdata_reg <= OUT_W'({hs_reg, ts_reg, res_posture_reg});
                    m_tuser_reg <= res_full_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/sssfd_window_mem.sv @@
// sssfd_window_mem: storage of the top y and height windows
// one write port, one registered read port shared by both windows

module sssfd_window_mem
    import sssfd_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
    input  logic [COORD_BITS-1:0]        top_wr,
    input  logic signed [COORD_BITS:0]   hgt_wr,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_addr,
    output logic [COORD_BITS-1:0]        top_rd_reg,
    output logic signed [COORD_BITS:0]   hgt_rd_reg
);

    logic [COORD_BITS-1:0] top_mem [MAX_WINDOW];
    logic signed [COORD_BITS:0] hgt_mem [MAX_WINDOW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            top_mem[wr_addr] <= top_wr;
            hgt_mem[wr_addr] <= hgt_wr;
        end
    end

    always_ff @(posedge aclk) begin
        top_rd_reg <= top_mem[rd_addr];
        hgt_rd_reg <= hgt_mem[rd_addr];
    end

endmodule

@@ rtl/core/sssfd_slope_unit.sv @@
// sssfd_slope_unit: shared multiplier and restoring divider for one slope
// slope = (n*sxy - sx*sy) / den, truncated toward zero, saturated; uses sssfd_pkg

module sssfd_slope_unit
    import sssfd_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int COORD_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] n,
    input  logic [2*$clog2(MAX_WINDOW+1)-1:0] sx,
    input  logic [4*$clog2(MAX_WINDOW+1)-1:0] den,
    input  logic signed [COORD_BITS+$clog2(MAX_WINDOW+1):0] sy,
    input  logic signed [COORD_BITS+2*$clog2(MAX_WINDOW+1):0] sxy,
    output logic done,
    output logic signed [COORD_BITS:0] slope
);

    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int SXW = 2 * NW;
    localparam int DENW = 4 * NW;
    localparam int SXYW = COORD_BITS + 2 * NW + 1;
    localparam int PW = SXW + 1 + SXYW;
    localparam int RW = ((PW + 1 > DENW + COORD_BITS) ? PW + 1 : DENW + COORD_BITS) + 1;
    localparam int KW = $clog2(COORD_BITS + 1);

    slope_state_t state_reg, state_next;

    logic signed [PW-1:0] pa_reg, pb_reg;
    logic [RW-1:0] rem_reg, dsh_reg;
    logic [COORD_BITS:0] q_reg;
    logic neg_reg;
    logic [KW-1:0] kc_reg;

    logic signed [SXW:0] mul_a;
    logic signed [SXYW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW:0] diff;
    logic [PW:0] diff_mag;
    logic take;
    logic [COORD_BITS-1:0] q_mag;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SL_IDLE: if (start) state_next = SL_MUL_A;
            SL_MUL_A: state_next = SL_MUL_B;
            SL_MUL_B: state_next = SL_SUB;
            SL_SUB: state_next = SL_DIV;
            SL_DIV: if (kc_reg == '0) state_next = SL_DONE;
            // a start here chains the second slope straight after the first
            SL_DONE: state_next = start ? SL_MUL_A : SL_IDLE;
            default: state_next = SL_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        done = (state_reg == SL_DONE);
        q_mag = q_reg[COORD_BITS] ? {COORD_BITS{1'b1}} : q_reg[COORD_BITS-1:0];
        slope = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // one multiplier, shared by both products
    always_comb begin
        mul_a = (state_reg == SL_MUL_A) ? $signed({1'b0, SXW'(n)}) : $signed({1'b0, sx});
        mul_b = (state_reg == SL_MUL_A) ? sxy : SXYW'(sy);
        prod = PW'(mul_a) * PW'(mul_b);
        diff = (PW + 1)'(pa_reg) - (PW + 1)'(pb_reg);
        diff_mag = diff[PW] ? $unsigned(-diff) : $unsigned(diff);
        take = (rem_reg >= dsh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SL_MUL_A: pa_reg <= prod;
            SL_MUL_B: pb_reg <= prod;
            SL_SUB: begin
                neg_reg <= diff[PW];
                rem_reg <= RW'(diff_mag);
                dsh_reg <= RW'(den) << COORD_BITS;
                q_reg <= '0;
                kc_reg <= KW'(COORD_BITS);
            end
            SL_DIV: begin
                // top quotient bit set means the quotient is past the saturation limit
                if (take) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg <= {q_reg[COORD_BITS-1:0], take};
                dsh_reg <= dsh_reg >> 1;
                kc_reg <= kc_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
